// File: rtl/core/length_prefixed_frame_receiver_crc16_macros.svh
// assertion helpers for the frame receiver datapath file
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_CRC16_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_CRC16_MACROS_SVH

// condition implies consequence in the same cycle
`define LPFR_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);

// condition implies consequence in the next cycle
`define LPFR_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: rtl/core/lpfr_pkg.sv
package lpfr_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = AW + 1;
    localparam int LW = 16;
    localparam int TW = LW + 1;
    localparam int MIN_SCAN = 6;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [1:0] CMD_RX      = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] REG_SHORT = 2'd0;
    localparam logic [1:0] REG_LONG  = 2'd1;
    localparam logic [1:0] REG_STOP  = 2'd2;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_LATCH      = 5'd1;
    localparam t_op OP_SCAN_BEGIN = 5'd2;
    localparam t_op OP_RD_IDX0    = 5'd3;
    localparam t_op OP_DROP       = 5'd4;
    localparam t_op OP_HDR_SHORT  = 5'd5;
    localparam t_op OP_HDR_LONG   = 5'd6;
    localparam t_op OP_LEN_SHORT  = 5'd7;
    localparam t_op OP_LEN_HI     = 5'd8;
    localparam t_op OP_LEN_LO     = 5'd9;
    localparam t_op OP_RD_STOP    = 5'd10;
    localparam t_op OP_HOLD       = 5'd11;
    localparam t_op OP_APPLY      = 5'd12;
    localparam t_op OP_CRC_INIT   = 5'd13;
    localparam t_op OP_CRC_RD     = 5'd14;
    localparam t_op OP_CRC_ACC    = 5'd15;
    localparam t_op OP_RD_RCVH    = 5'd16;
    localparam t_op OP_RCVH       = 5'd17;
    localparam t_op OP_RCVL       = 5'd18;
    localparam t_op OP_CB         = 5'd19;
    localparam t_op OP_FINISH     = 5'd20;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_lt6;
        logic fill_zero;
        logic fill_lt2;
        logic fill_lt3;
        logic b0_short;
        logic b0_long;
        logic is_short;
        logic total_big;
        logic fill_lt_total;
        logic stop_match;
        logic crc_done;
        logic held;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/length_prefixed_frame_receiver_crc16.sv
// Byte-stream frame receiver: each request carries a command (receive a byte, read a body
// byte, release the held frame, clear) and returns one result describing the settled
// buffer. One request at a time is worked, through a 512-byte store with one write port and
// one read port, read one byte per cycle. A request scans the store, applies its command and
// scans again; a scan ends without reading while the store holds fewer than six bytes, drops
// leading bytes that match no start code and restarts after a rejected start-code attempt;
// a held frame then adds a CRC walk over its body bytes. A new request is taken while the
// previous result waits in the output register; the finishing step of a request waits
// while the result before it is still unaccepted.
// The store needs no clearing pass after reset.
module length_prefixed_frame_receiver_crc16
    import lpfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // cmd[1:0], rx_byte[9:2], read_offset[18:10]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // frame_ready[0], crc_good[1], command_byte[9:2], body_length[19:10],
    // read_data[27:20], overflow[28]
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     idle;

    assign o_s_axis_tready = idle;
    assign o_cfg_ready     = 1'b1;

    lpfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_axis_tvalid && idle),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    lpfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/core/lpfr_ctrl.sv
module lpfr_ctrl
    import lpfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_idle
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_INNER = 4'd2;
    localparam logic [3:0] ST_B0    = 4'd3;
    localparam logic [3:0] ST_B1    = 4'd4;
    localparam logic [3:0] ST_B2    = 4'd5;
    localparam logic [3:0] ST_TOT   = 4'd6;
    localparam logic [3:0] ST_STOP  = 4'd7;
    localparam logic [3:0] ST_SEND  = 4'd8;
    localparam logic [3:0] ST_APPLY = 4'd9;
    localparam logic [3:0] ST_CRC   = 4'd10;
    localparam logic [3:0] ST_ACC   = 4'd11;
    localparam logic [3:0] ST_RCVH  = 4'd12;
    localparam logic [3:0] ST_RCVL  = 4'd13;
    localparam logic [3:0] ST_CB    = 4'd14;
    localparam logic [3:0] ST_FIN   = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_post, n_post;
    t_op        op;

    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        op      = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    op      = OP_LATCH;
                    n_post  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                op      = OP_SCAN_BEGIN;
                n_state = i_stat.fill_lt6 ? ST_SEND : ST_INNER;
            end
            ST_INNER: begin
                if (i_stat.fill_zero) begin
                    n_state = ST_SEND;
                end else begin
                    op      = OP_RD_IDX0;
                    n_state = ST_B0;
                end
            end
            ST_B0: begin
                // short form wins when both start codes match
                priority if (i_stat.b0_short) begin
                    if (i_stat.fill_lt2) begin
                        n_state = ST_SEND;
                    end else begin
                        op      = OP_HDR_SHORT;
                        n_state = ST_B1;
                    end
                end else if (i_stat.b0_long) begin
                    if (i_stat.fill_lt3) begin
                        n_state = ST_SEND;
                    end else begin
                        op      = OP_HDR_LONG;
                        n_state = ST_B1;
                    end
                end else begin
                    op      = OP_DROP;
                    n_state = ST_INNER;
                end
            end
            ST_B1: begin
                if (i_stat.is_short) begin
                    op      = OP_LEN_SHORT;
                    n_state = ST_TOT;
                end else begin
                    op      = OP_LEN_HI;
                    n_state = ST_B2;
                end
            end
            ST_B2: begin
                op      = OP_LEN_LO;
                n_state = ST_TOT;
            end
            ST_TOT: begin
                priority if (i_stat.total_big) begin
                    op      = OP_DROP;
                    n_state = ST_SCAN;
                end else if (i_stat.fill_lt_total) begin
                    n_state = ST_SEND;
                end else begin
                    op      = OP_RD_STOP;
                    n_state = ST_STOP;
                end
            end
            ST_STOP: begin
                if (i_stat.stop_match) begin
                    op      = OP_HOLD;
                    n_state = ST_SEND;
                end else begin
                    op      = OP_DROP;
                    n_state = ST_SCAN;
                end
            end
            ST_SEND: begin
                priority if (!r_post) begin
                    n_state = ST_APPLY;
                end else if (i_stat.held) begin
                    op      = OP_CRC_INIT;
                    n_state = ST_CRC;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_APPLY: begin
                op      = OP_APPLY;
                n_post  = 1'b1;
                n_state = ST_SCAN;
            end
            ST_CRC: begin
                if (i_stat.crc_done) begin
                    op      = OP_RD_RCVH;
                    n_state = ST_RCVH;
                end else begin
                    op      = OP_CRC_RD;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                op      = OP_CRC_ACC;
                n_state = ST_CRC;
            end
            ST_RCVH: begin
                op      = OP_RCVH;
                n_state = ST_RCVL;
            end
            ST_RCVL: begin
                op      = OP_RCVL;
                n_state = ST_CB;
            end
            ST_CB: begin
                op      = OP_CB;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // result register still waiting: hold here
                op = OP_FINISH;
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

    assign o_cmd.op = op;
    assign o_idle   = (r_state == ST_IDLE);

endmodule

// File: rtl/core/lpfr_dp.sv
module lpfr_dp
    import lpfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [23:0] i_in_data,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_data
);

    `include "length_prefixed_frame_receiver_crc16_macros.svh"

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    r_rdata;

    logic [7:0]    r_short, r_long, r_stop;
    logic [1:0]    r_cmd;
    logic [7:0]    r_rx;
    logic [8:0]    r_off;

    logic [AW-1:0] r_front;
    logic [FW-1:0] r_fill;
    logic          r_held;
    logic [1:0]    r_hdr;
    logic [LW-1:0] r_len;
    logic [7:0]    r_len_hi;
    logic [15:0]   r_crc;
    logic [FW-1:0] r_ci;
    logic [7:0]    r_rcv_hi;
    logic [7:0]    r_rcv_lo;
    logic [7:0]    r_cb;
    logic          r_ovf;

    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic [TW-1:0] total;
    logic [AW-1:0] idx;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic          rd_hit;
    logic          we;
    t_op           op;

    assign op    = i_cmd.op;
    assign total = TW'(r_hdr) + TW'(r_len) + TW'(3);
    assign full  = (r_fill == FW'(BUFFER_DEPTH));
    assign rd_hit = r_held && (r_cmd == CMD_READ) && (LW'(r_off) < r_len);
    assign we    = (op == OP_APPLY) && (r_cmd == CMD_RX) && !full;

    always_comb begin
        unique case (op)
            OP_HDR_SHORT, OP_HDR_LONG: idx = AW'(1);
            OP_LEN_HI:                 idx = AW'(2);
            OP_RD_STOP:                idx = total[AW-1:0] - AW'(1);
            OP_CRC_RD:                 idx = AW'(r_hdr) + r_ci[AW-1:0];
            OP_RD_RCVH:                idx = total[AW-1:0] - AW'(3);
            OP_RCVH:                   idx = total[AW-1:0] - AW'(2);
            OP_RCVL:                   idx = AW'(r_hdr);
            OP_CB, OP_FINISH:          idx = AW'(r_hdr) + r_off[AW-1:0];
            default:                   idx = '0;
        endcase
    end

    assign rd_addr = r_front + idx;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_front + r_fill[AW-1:0]] <= r_rx;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= 8'd2;
            r_long  <= 8'd3;
            r_stop  <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHORT: r_short <= i_cfg_data;
                REG_LONG:  r_long  <= i_cfg_data;
                REG_STOP:  r_stop  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_fill      <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((op == OP_FINISH) && !(r_out_valid && !i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (op)
                OP_SCAN_BEGIN: r_held <= 1'b0;
                OP_DROP: begin
                    r_front <= r_front + AW'(1);
                    r_fill  <= r_fill - FW'(1);
                end
                OP_HOLD: r_held <= 1'b1;
                OP_APPLY: begin
                    unique case (r_cmd)
                        CMD_RX: begin
                            if (!full) begin
                                r_fill <= r_fill + FW'(1);
                            end
                        end
                        CMD_RELEASE: begin
                            if (r_held) begin
                                r_front <= r_front + total[AW-1:0];
                                r_fill  <= r_fill - total[FW-1:0];
                            end
                        end
                        CMD_CLEAR: begin
                            r_front <= '0;
                            r_fill  <= '0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_LATCH: begin
                r_cmd <= i_in_data[1:0];
                r_rx  <= i_in_data[9:2];
                r_off <= i_in_data[18:10];
                r_ovf <= 1'b0;
            end
            OP_HDR_SHORT: r_hdr <= 2'd2;
            OP_HDR_LONG:  r_hdr <= 2'd3;
            OP_LEN_SHORT: r_len <= LW'(r_rdata);
            OP_LEN_HI:    r_len_hi <= r_rdata;
            OP_LEN_LO:    r_len <= {r_len_hi, r_rdata};
            OP_APPLY: begin
                if ((r_cmd == CMD_RX) && full) begin
                    r_ovf <= 1'b1;
                end
            end
            OP_CRC_INIT: begin
                r_crc <= 16'h0000;
                r_ci  <= '0;
            end
            OP_CRC_ACC: begin
                r_crc <= crc_byte(r_crc, r_rdata);
                r_ci  <= r_ci + FW'(1);
            end
            OP_RCVH: r_rcv_hi <= r_rdata;
            OP_RCVL: r_rcv_lo <= r_rdata;
            OP_CB:   r_cb <= (r_len != '0) ? r_rdata : 8'h00;
            OP_FINISH: begin
                if (!(r_out_valid && !i_out_ready)) begin
                    r_out_data <= {3'b000,
                                   r_ovf,
                                   rd_hit ? r_rdata : 8'h00,
                                   r_held ? r_len[9:0] : 10'd0,
                                   r_held ? r_cb : 8'h00,
                                   r_held && ({r_rcv_hi, r_rcv_lo} == r_crc),
                                   r_held};
                end
            end
            default: ;
        endcase
    end

    assign o_stat.fill_lt6      = (r_fill < FW'(MIN_SCAN));
    assign o_stat.fill_zero     = (r_fill == '0);
    assign o_stat.fill_lt2      = (r_fill < FW'(2));
    assign o_stat.fill_lt3      = (r_fill < FW'(3));
    assign o_stat.b0_short      = (r_rdata == r_short);
    assign o_stat.b0_long       = (r_rdata == r_long);
    assign o_stat.is_short      = (r_hdr == 2'd2);
    assign o_stat.total_big     = (total > TW'(BUFFER_DEPTH));
    assign o_stat.fill_lt_total = (TW'(r_fill) < total);
    assign o_stat.stop_match    = (r_rdata == r_stop);
    assign o_stat.crc_done      = (LW'(r_ci) == r_len);
    assign o_stat.held          = r_held;
    assign o_stat.out_busy      = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LPFR_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FW'(BUFFER_DEPTH), "fill count beyond depth")
    `LPFR_ASSERT_NXT(a_rx_grows, we, r_fill == $past(r_fill) + FW'(1), "stored byte not counted")
    `LPFR_ASSERT_IMP(a_held_hdr, r_held && (op == OP_CRC_ACC), (r_hdr == 2'd2) || (r_hdr == 2'd3), "held frame without header size")
    `LPFR_ASSERT_NXT(a_valid_src, !r_out_valid, !r_out_valid || ($past(op) == OP_FINISH), "result shown without finish")

endmodule

// File: dv/length_prefixed_frame_receiver_crc16_tb.sv
`timescale 1ns / 100ps

module length_prefixed_frame_receiver_crc16_tb;
    import lpfr_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [8:0] read_offset;
    } t_request;

    typedef struct {
        logic       frame_ready;
        logic       crc_good;
        logic [7:0] command_byte;
        logic [9:0] body_length;
        logic [7:0] read_data;
        logic       overflow;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    length_prefixed_frame_receiver_crc16 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_request pending_q[$];
    t_status  status_q[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_cnt = 0;
    int       cycle_cnt = 0;
    int       sent_cnt = 0;
    int       seen_cnt = 0;
    int       frames_seen = 0;
    int       overflow_seen = 0;

    // mirror of the receiver
    logic [7:0] m_short = 8'd2, m_long = 8'd3, m_stop = 8'd3;
    logic [7:0] m_store [BUFFER_DEPTH];
    int m_front = 0, m_fill = 0;
    bit m_held = 0;
    int m_hdr = 0, m_len = 0, m_total = 0;

    // codes as the stimulus sees them, updated with each register write
    logic [7:0] m_short_code = 8'd2, m_long_code = 8'd3, m_stop_code = 8'd3;

    function automatic logic [7:0] at(int i);
        return m_store[(m_front + i) % BUFFER_DEPTH];
    endfunction

    function automatic void pop_front();
        if (m_fill > 0) begin
            m_front = (m_front + 1) % BUFFER_DEPTH;
            m_fill--;
        end
    endfunction

    function automatic void resync();
        m_held = 0;
        forever begin
            if (m_fill < 6) return;
            while (m_fill > 0 && at(0) != m_short && at(0) != m_long) pop_front();
            if (m_fill == 0) return;
            if (at(0) == m_short) begin
                if (m_fill < 2) return;
                m_len = at(1);
                m_hdr = 2;
            end else begin
                if (m_fill < 3) return;
                m_len = {at(1), at(2)};
                m_hdr = 3;
            end
            m_total = m_hdr + m_len + 3;
            if (m_total > BUFFER_DEPTH) begin
                pop_front();
                continue;
            end
            if (m_fill < m_total) return;
            if (at(m_total - 1) != m_stop) begin
                pop_front();
                continue;
            end
            m_held = 1;
            return;
        end
    endfunction

    function automatic logic [15:0] xmodem_crc(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ (16'(b) << 8);
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic t_status predict_status(t_request r);
        t_status s;
        logic [15:0] crc;
        s = '{default: '0};
        resync();
        case (r.cmd)
            CMD_RX: begin
                if (m_fill >= BUFFER_DEPTH) s.overflow = 1'b1;
                else begin
                    m_store[(m_front + m_fill) % BUFFER_DEPTH] = r.rx_byte;
                    m_fill++;
                end
            end
            CMD_RELEASE: if (m_held) for (int i = 0; i < m_total; i++) pop_front();
            CMD_CLEAR: begin
                m_front = 0;
                m_fill = 0;
            end
            default: ;
        endcase
        resync();
        if (m_held) begin
            crc = '0;
            for (int i = 0; i < m_len; i++) crc = xmodem_crc(crc, at(m_hdr + i));
            s.frame_ready = 1'b1;
            s.crc_good = ({at(m_total - 3), at(m_total - 2)} == crc);
            s.command_byte = (m_len > 0) ? at(m_hdr) : 8'd0;
            s.body_length = m_len[9:0];
            if (r.cmd == CMD_READ && r.read_offset < m_len)
                s.read_data = at(m_hdr + r.read_offset);
        end
        return s;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                status_q.insert(status_q.size(), predict_status(pending_q.pop_front()));
                sent_cnt++;
            end
            if ((!s_tvalid || s_tready)) begin
                if ((s_tvalid && s_tready ? pending_q.size() > 0 : pending_q.size() > 0)
                        && $urandom_range(1, 100) > send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, pending_q[0].read_offset, pending_q[0].rx_byte,
                                pending_q[0].cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.frame_ready = m_tdata[0];
                got.crc_good = m_tdata[1];
                got.command_byte = m_tdata[9:2];
                got.body_length = m_tdata[19:10];
                got.read_data = m_tdata[27:20];
                got.overflow = m_tdata[28];
                seen_cnt++;
                if (status_q.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = status_q.pop_front();
                    frames_seen += got.frame_ready;
                    overflow_seen += got.overflow;
                    if (got.frame_ready !== want.frame_ready) begin
                        $error("frame_ready exp %0d got %0d", want.frame_ready, got.frame_ready);
                        fail_cnt++;
                    end
                    if (got.crc_good !== want.crc_good) begin
                        $error("crc_good exp %0d got %0d", want.crc_good, got.crc_good);
                        fail_cnt++;
                    end
                    if (got.command_byte !== want.command_byte) begin
                        $error("command_byte exp %0d got %0d", want.command_byte,
                               got.command_byte);
                        fail_cnt++;
                    end
                    if (got.body_length !== want.body_length) begin
                        $error("body_length exp %0d got %0d", want.body_length,
                               got.body_length);
                        fail_cnt++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $error("read_data exp %0d got %0d", want.read_data, got.read_data);
                        fail_cnt++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow exp %0d got %0d", want.overflow, got.overflow);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void add_request(logic [1:0] c, logic [7:0] b, logic [8:0] o);
        t_request r;
        r.cmd = c;
        r.rx_byte = b;
        r.read_offset = o;
        pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        add_request(CMD_RX, b, 9'($urandom));
    endfunction

    // one frame on the wire; crc and stop can be spoilt on request
    function automatic void add_frame(bit long_form, int len, bit bad_crc, bit bad_stop);
        logic [15:0] crc;
        logic [7:0] b;
        crc = '0;
        add_byte(long_form ? m_long_code : m_short_code);
        if (long_form) add_byte(len[15:8]);
        add_byte(len[7:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            crc = xmodem_crc(crc, b);
            add_byte(b);
        end
        if (bad_crc) crc = crc ^ 16'(1 << $urandom_range(0, 15));
        add_byte(crc[15:8]);
        add_byte(crc[7:0]);
        add_byte(bad_stop ? m_stop_code + 8'(1 + $urandom_range(0, 254)) : m_stop_code);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SHORT: begin m_short = val; m_short_code = val; end
            REG_LONG:  begin m_long = val; m_long_code = val; end
            default:   begin m_stop = val; m_stop_code = val; end
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || status_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n);
        int start;
        int len;
        start = sent_cnt + pending_q.size();
        while (sent_cnt + pending_q.size() - start < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                      : $urandom_range(0, 12);
                    add_frame($urandom_range(0, 2) == 0, len, $urandom_range(0, 4) == 0,
                              $urandom_range(0, 6) == 0);
                    repeat ($urandom_range(0, 3))
                        add_request(CMD_READ, 8'($urandom),
                                    $urandom_range(0, 1) ? 9'($urandom_range(0, len + 1))
                                                         : 9'($urandom));
                    if ($urandom_range(0, 3) != 0) add_request(CMD_RELEASE, 8'($urandom),
                                                               9'($urandom));
                end
                5, 6: repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
                7: add_request(2'($urandom), 8'($urandom), 9'($urandom));
                8: add_request(CMD_READ, 8'($urandom), 9'($urandom));
                default: add_request(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_RELEASE,
                                     8'($urandom), 9'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [7:0] codes [5][3];
        codes = '{'{8'd2, 8'd3, 8'd3}, '{8'd0, 8'd255, 8'd255}, '{8'h7e, 8'h7e, 8'h55},
                  '{8'd255, 8'd0, 8'd0}, '{8'hc0, 8'h35, 8'h9a}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, frame variants, too-long frame
        add_request(CMD_READ, 8'hff, 9'h1ff);
        add_request(CMD_RELEASE, 8'h00, 9'h000);
        add_frame(0, 0, 0, 0);
        add_byte(8'h00);
        add_request(CMD_READ, 8'h00, 9'd0);
        add_request(CMD_RELEASE, 8'h00, 9'd0);
        add_frame(0, 2, 0, 1);
        add_byte(8'hff);
        add_request(CMD_CLEAR, 8'h00, 9'd0);
        add_byte(m_long_code);
        repeat (5) add_byte(8'hff);
        add_request(CMD_CLEAR, 8'h00, 9'd0);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_reg(REG_SHORT, codes[p][0]);
            write_reg(REG_LONG, codes[p][1]);
            write_reg(REG_STOP, codes[p][2]);
            for (int mode = 0; mode < 4; mode++) begin
                send_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 18 : 0;
                recv_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 18 : 0;
                random_traffic(10);
                // hold the sender until everything outstanding has returned
                drain();
            end
        end

        $display("covered %0d requests over 5 code settings and 4 idling patterns",
                 sent_cnt);
        $display("results %0d, with a frame held %0d, overflow drops %0d",
                 seen_cnt, frames_seen, overflow_seen);
        if (fail_cnt == 0 && status_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
